// File: hdl/iobp_pkg.sv
// iobp_pkg: shared types and constants for the interval overlap bound probability block
// no dependencies
`default_nettype none
package iobp_pkg;
   localparam int unsigned MaxPeaksDefault = 4096;
   localparam int unsigned ProbFracBitsDefault = 16;
   localparam int unsigned PosW = 31;
   localparam int unsigned SpanW = 20;
   localparam int unsigned ScoreW = 17;
   localparam int unsigned CountW = 13;
   localparam int unsigned StatusW = 2;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [StatusW-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_ZERO  = 2'd2,
      ST_SPARE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_MULT,
      S_DIV,
      S_PROD,
      S_SHIFT,
      S_DONE
   } state_type;

   typedef struct packed {
      opcode_type       opcode;
      logic [PosW-1:0]  position;
      logic [SpanW-1:0] span;
      logic [ScoreW-1:0] bound_score;
   } req_type;

   typedef struct packed {
      logic [ScoreW-1:0]  prob_bound;
      logic [CountW-1:0]  overlap_count;
      logic [CountW-1:0]  cursor_now;
      status_type         status;
   } rsp_type;
endpackage
`default_nettype wire

// File: hdl/iobp_divider.sv
// iobp_divider: radix-2 restoring divider, one quotient bit per cycle
// uses iobp_pkg
`default_nettype none
module iobp_divider import iobp_pkg::*; #(
   parameter int unsigned NumW = 64,
   parameter int unsigned DenW = SpanW
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [NumW-1:0] numer,
   input  wire logic [DenW-1:0] denom,
   output logic                 done,
   output logic [NumW-1:0]      quot
);
   localparam int unsigned CntW = $clog2(NumW + 1);
   logic [NumW-1:0] q_ff, q_in;
   logic [DenW:0]   r_ff, r_in;
   logic [DenW-1:0] d_ff, d_in;
   logic [CntW-1:0] n_ff, n_in;
   logic            busy_ff, busy_in;
   logic [DenW:0]   trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      n_in = n_ff;
      busy_in = busy_ff;
      trial = {r_ff[DenW-1:0], q_ff[NumW-1]};
      if (start) begin
         q_in = numer;
         r_in = '0;
         d_in = denom;
         n_in = CntW'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NumW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NumW-2:0], 1'b0};
         end
         n_in = n_ff - 1'b1;
         if (n_ff == CntW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      n_ff <= n_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign done = busy_ff && (n_ff == CntW'(1));
   assign quot = q_in;
endmodule
`default_nettype wire

// File: hdl/interval_overlap_bound_probability.sv
// interval_overlap_bound_probability: peak table in memory with a walking overlap query
// uses iobp_pkg and iobp_divider
//
//   channel | direction | payload  | handshake
//   req     | in        | req_type | req_valid / req_ready
//   rsp     | out       | rsp_type | rsp_valid / rsp_ready
//
// clear and append pass through the done state; a query visits read and eval per peak
// passed, plus mult, the serial divider (one quotient bit a cycle), prod and shift per
// overlapping peak, or only read and eval for a zero span; a later peak ends the walk
// one item in flight; the table memory has a registered read
// synchronous reset clears count, cursor and control; table contents undefined
// a held result blocks req_ready until rsp is taken
`default_nettype none
module interval_overlap_bound_probability import iobp_pkg::*; #(
   parameter int unsigned MAX_PEAKS = MaxPeaksDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire req_type req_data,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output rsp_type   rsp_data
);
   localparam int unsigned PROB_FRAC_BITS = ProbFracBitsDefault;
   localparam int unsigned AddrW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
   localparam int unsigned TotW = $clog2(MAX_PEAKS + 1);
   localparam int unsigned PW = PROB_FRAC_BITS + 1;
   localparam int unsigned ProdW = 2 * PW;
   localparam int unsigned MulW = SpanW + ScoreW;
   localparam int unsigned EndW = PosW + 1;
   localparam logic [PW-1:0] One = PW'(1) << PROB_FRAC_BITS;
   localparam int unsigned EntW = PosW + SpanW + ScoreW;

   logic [EntW-1:0] table_mem [MAX_PEAKS];
   logic [EntW-1:0] rd_ff;
   logic            wr_en;
   logic [AddrW-1:0] wr_addr, rd_addr;
   logic [EntW-1:0] wr_data;

   state_type state_ff, state_in;
   logic [TotW-1:0] total_ff, total_in, cur_ff, cur_in, idx_ff, idx_in;
   logic [CountW-1:0] cnt_ff, cnt_in;
   req_type req_ff, req_in;
   logic [PW-1:0] prod_ff, prod_in, term_ff, term_in;
   logic [MulW-1:0] mul_ff, mul_in;
   logic [ProdW-1:0] pp_ff, pp_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [PosW-1:0] p_start;
   logic [SpanW-1:0] p_len;
   logic [ScoreW-1:0] p_score;
   logic [EndW-1:0] p_end, f_end, lo, hi;
   logic div_start, div_done;
   logic [MulW-1:0] div_q;
   logic [ScoreW-1:0] sat_score;

   assign {p_start, p_len, p_score} = rd_ff;
   assign p_end = {1'b0, p_start} + EndW'(p_len);
   assign f_end = {1'b0, req_ff.position} + EndW'(req_ff.span);
   assign lo = (p_start > req_ff.position) ? {1'b0, p_start} : {1'b0, req_ff.position};
   assign hi = (p_end < f_end) ? p_end : f_end;
   assign sat_score = (req_data.bound_score > ScoreW'(One)) ? ScoreW'(One)
                                                            : req_data.bound_score;

   iobp_divider #(.NumW(MulW), .DenW(SpanW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(mul_ff),
      .denom(req_ff.span), .done(div_done), .quot(div_q)
   );

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign rd_addr = idx_ff[AddrW-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid && req_ready && req_data.opcode == OP_QUERY) state_in = S_READ;
            else if (req_valid && req_ready) state_in = S_DONE;
         S_READ: state_in = (idx_ff < total_ff) ? S_EVAL : S_DONE;
         S_EVAL: begin
            if (f_end <= {1'b0, p_start}) state_in = S_DONE;
            else if ({1'b0, req_ff.position} >= p_end) state_in = S_READ;
            else if (req_ff.span == '0) state_in = S_READ;
            else state_in = S_MULT;
         end
         S_MULT: state_in = S_DIV;
         S_DIV: if (div_done) state_in = S_PROD;
         S_PROD: state_in = S_SHIFT;
         S_SHIFT: state_in = S_READ;
         S_DONE: if (!rsp_valid_ff) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      total_in = total_ff;
      cur_in = cur_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      req_in = req_ff;
      prod_in = prod_ff;
      term_in = term_ff;
      mul_in = mul_ff;
      pp_in = pp_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en = 1'b0;
      wr_addr = total_ff[AddrW-1:0];
      wr_data = {req_data.position, req_data.span, sat_score};
      div_start = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            req_in = req_data;
            idx_in = cur_ff;
            cnt_in = '0;
            prod_in = One;
            rsp_in.prob_bound = '0;
            rsp_in.overlap_count = '0;
            rsp_in.status = ST_OK;
            unique case (req_data.opcode)
               OP_CLEAR: begin
                  total_in = '0;
                  cur_in = '0;
               end
               OP_APPEND: begin
                  if (total_ff >= TotW'(MAX_PEAKS)) rsp_in.status = ST_FULL;
                  else begin
                     wr_en = 1'b1;
                     total_in = total_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_READ: ;
         S_EVAL: begin
            if (f_end <= {1'b0, p_start}) ;
            else if ({1'b0, req_ff.position} >= p_end) begin
               cur_in = cur_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
               mul_in = MulW'(hi - lo) * MulW'(p_score);
            end
         end
         S_MULT: div_start = 1'b1;
         S_DIV: if (div_done)
            term_in = (div_q > MulW'(One)) ? One : PW'(div_q);
         S_PROD: pp_in = ProdW'(prod_ff) * ProdW'(One - term_ff);
         S_SHIFT: prod_in = PW'(pp_ff >> PROB_FRAC_BITS);
         S_DONE: if (!rsp_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in.cursor_now = CountW'(cur_ff);
            if (req_ff.opcode == OP_QUERY) begin
               rsp_in.overlap_count = cnt_ff;
               if (req_ff.span == '0) rsp_in.status = ST_ZERO;
               else if (cnt_ff != '0) rsp_in.prob_bound = ScoreW'(One - prod_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) table_mem[wr_addr] <= wr_data;
      rd_ff <= table_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      prod_ff <= prod_in;
      term_ff <= term_in;
      mul_ff <= mul_in;
      pp_ff <= pp_in;
      rsp_ff <= rsp_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         cur_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         cur_ff <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

// File: hdl/iobp_checker.sv
// iobp_checker: port-level assertions for the top level, with its bind
// uses iobp_pkg
`default_nettype none
module iobp_checker import iobp_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req taken with result pending");
   a_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transfer accepted back to back");
   a_status_prob: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.prob_bound == '0)
      else $error("probability with error status");
endmodule

bind interval_overlap_bound_probability iobp_checker u_iobp_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
`default_nettype wire

// File: tb/interval_overlap_bound_probability_tb.sv
// interval_overlap_bound_probability_tb: self-checking bench for the peak table overlap query block
// drives clear, append, query and no-op transfers, predicts each response, compares field by field
// depends on iobp_pkg and the interval_overlap_bound_probability rtl
`default_nettype none
module interval_overlap_bound_probability_tb import iobp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TablePeaks = MaxPeaksDefault;
   localparam longint unsigned ProbOne = 64'd1 << ProbFracBitsDefault;
   localparam int unsigned CycleLimit = 5000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_req[$];
   rsp_type expected_rsp[$];
   int unsigned cycle_count = 0;
   int unsigned hold_left = 0;
   int unsigned error_count = 0;
   bit quiet;

   longint unsigned tbl_begin[TablePeaks];
   longint unsigned peak_len[TablePeaks];
   longint unsigned peak_score[TablePeaks];
   int unsigned peak_count = 0;
   int unsigned cursor = 0;

   interval_overlap_bound_probability u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   assign quiet = (cycle_count >= 20000) && (cycle_count < 32000);

   function automatic rsp_type bound_probability(req_type r);
      rsp_type o;
      longint unsigned f_end, prod, hits, p_end, lo, hi, term, score;
      o = '0;
      o.status = ST_OK;
      case (r.opcode)
         OP_CLEAR: begin
            peak_count = 0;
            cursor = 0;
         end
         OP_APPEND: begin
            if (peak_count >= TablePeaks) begin
               o.status = ST_FULL;
            end else begin
               score = r.bound_score;
               if (score > ProbOne) score = ProbOne;
               tbl_begin[peak_count] = r.position;
               peak_len[peak_count] = r.span;
               peak_score[peak_count] = score;
               peak_count++;
            end
         end
         OP_QUERY: begin
            f_end = longint'(r.position) + r.span;
            prod = ProbOne;
            hits = 0;
            for (int unsigned i = cursor; i < peak_count; i++) begin
               p_end = tbl_begin[i] + peak_len[i];
               if (f_end <= tbl_begin[i]) break;
               if (r.position >= p_end) begin
                  cursor++;
               end else begin
                  lo = (tbl_begin[i] > r.position) ? tbl_begin[i] : r.position;
                  hi = (p_end < f_end) ? p_end : f_end;
                  hits++;
                  if (r.span != 0) begin
                     term = ((hi - lo) * peak_score[i]) / r.span;
                     if (term > ProbOne) term = ProbOne;
                     prod = (prod * (ProbOne - term)) >> ProbFracBitsDefault;
                  end
               end
            end
            o.overlap_count = hits[CountW-1:0];
            if (r.span == 0) o.status = ST_ZERO;
            else if (hits != 0) o.prob_bound = ScoreW'(ProbOne - prod);
         end
         default: ;
      endcase
      o.cursor_now = cursor[CountW-1:0];
      return o;
   endfunction

   task automatic add_item(opcode_type op, longint unsigned pos, int unsigned len,
                           int unsigned score);
      req_type r;
      r.opcode = op;
      r.position = pos[PosW-1:0];
      r.span = len[SpanW-1:0];
      r.bound_score = score[ScoreW-1:0];
      pending_req.insert(pending_req.size(), r);
   endtask

   task automatic check_field(string name, longint unsigned exp, longint unsigned act);
      if (exp != act) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
         error_count++;
      end
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0);
   endtask

   always @(posedge clock) begin : sender
      logic next_valid;
      req_type next_data;
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else begin
         next_valid = req_valid && !req_ready;
         next_data = req_data;
         if (req_valid && req_ready)
            expected_rsp.insert(expected_rsp.size(), bound_probability(req_data));
         if (!next_valid && pending_req.size() != 0 && (quiet || $urandom_range(0, 99) >= 26)) begin
            next_data = pending_req.pop_front();
            next_valid = 1'b1;
         end
         req_valid <= next_valid;
         req_data <= next_data;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == 6000) hold_left <= 600;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      if (cycle_count >= CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin : receiver
      rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected transfer, actual %h", $time, rsp_data);
               error_count++;
            end else begin
               e = expected_rsp.pop_front();
               check_field("prob_bound", e.prob_bound, rsp_data.prob_bound);
               check_field("overlap_count", e.overlap_count, rsp_data.overlap_count);
               check_field("cursor_now", e.cursor_now, rsp_data.cursor_now);
               check_field("status", e.status, rsp_data.status);
            end
         end
         rsp_ready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 26);
      end
   end

   initial begin : stimulus
      int unsigned added;
      int unsigned n_peaks, n_queries, len, score;
      longint unsigned base, p, q;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      add_item(OP_QUERY, 0, 10, 0);
      add_item(OP_NONE, 32'h7fffffff, 20'hfffff, 17'h1ffff);
      add_item(OP_APPEND, 100, 50, 65536);
      add_item(OP_APPEND, 120, 100, 131071);
      add_item(OP_APPEND, 300, 0, 0);
      add_item(OP_APPEND, 400, 20, 32768);
      add_item(OP_QUERY, 90, 0, 0);
      add_item(OP_QUERY, 110, 20, 0);
      add_item(OP_QUERY, 130, 300, 0);
      add_item(OP_QUERY, 500, 10, 0);
      add_item(OP_NONE, 0, 0, 0);
      add_item(OP_CLEAR, 0, 0, 0);
      add_item(OP_APPEND, 500, 10, 40000);
      add_item(OP_APPEND, 100, 1000, 20000);
      add_item(OP_QUERY, 50, 1000, 0);
      add_item(OP_CLEAR, 0, 0, 0);
      add_item(OP_APPEND, 31'h7ff00000, 20'hfffff, 65535);
      add_item(OP_QUERY, 31'h7fffffff, 20'hfffff, 0);
      add_item(OP_QUERY, 0, 5, 0);
      drain();

      added = 0;
      while (added < 1580) begin
         if ($urandom_range(0, 99) < 80) begin
            base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5000)
                                               : $urandom_range(0, 32'h7ff00000);
            n_peaks = $urandom_range(1, 12);
            n_queries = $urandom_range(1, 8);
            add_item(OP_CLEAR, 0, 0, 0);
            p = base;
            for (int i = 0; i < n_peaks; i++) begin
               p += $urandom_range(0, 3000);
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20'hfffff)
                                                 : $urandom_range(0, 4000);
               score = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 17'h1ffff)
                                                   : $urandom_range(0, 65536);
               add_item(OP_APPEND, p, len, score);
            end
            q = (base > 1000) ? base - 1000 : 0;
            for (int i = 0; i < n_queries; i++) begin
               q += $urandom_range(0, 6000);
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20'hfffff)
                   : ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5000);
               add_item(OP_QUERY, q, len, $urandom_range(0, 17'h1ffff));
            end
            added += 1 + n_peaks + n_queries;
         end else begin
            add_item(opcode_type'($urandom_range(1, 3)), $urandom_range(0, 32'h7fffffff),
                     $urandom_range(0, 20'hfffff), $urandom_range(0, 17'h1ffff));
            added++;
         end
      end
      drain();
      repeat (200) @(posedge clock);
      if (error_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire
